@@ hw/rtl/apr_pkg.sv @@
// Shared constants, result kind codes and the date word decoder of the
// appointment record parser. It depends on nothing else.
package apr_pkg;

    localparam int DATA_W     = 8;
    localparam int KIND_W     = 3;
    localparam int M_TDATA_W  = 56;

    localparam int DESC_CAP_DEF   = 255;
    localparam int NOTE_CAP_DEF   = 511;
    localparam int EXCEPT_CAP_DEF = 16;

    localparam logic [KIND_W-1:0] KIND_HEADER = 3'd0;
    localparam logic [KIND_W-1:0] KIND_REPEAT = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DESC   = 3'd2;
    localparam logic [KIND_W-1:0] KIND_NOTE   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_END    = 3'd4;

    // Positions in the five-bit section flag word (flag byte bits 1 to 5).
    localparam int FLG_ALARM  = 0;
    localparam int FLG_REPEAT = 1;
    localparam int FLG_NOTE   = 2;
    localparam int FLG_EXC    = 3;
    localparam int FLG_DESC   = 4;

    localparam logic [7:0]  BYTE_ALL  = 8'hFF;
    localparam logic [15:0] WORD_ALL  = 16'hFFFF;
    localparam logic [10:0] YEAR_BASE = 11'd1904;

    typedef struct packed {
        logic [10:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } date_t;

    function automatic date_t decode_date(input logic [15:0] w);
        date_t d;
        d.year  = 11'(w[15:9]) + YEAR_BASE;
        d.month = w[8:5];
        d.day   = w[4:0];
        return d;
    endfunction

endpackage

@@ hw/rtl/appointment_record_parser_core.sv @@
// Appointment record parser top level: section sequencer and result register.
// Depends on apr_pkg for constants, kind codes and the date decoder.

// The parser takes one byte of a big-endian packed appointment record per item
// on the s_ channel and accepts a byte in every cycle unless a result waits and
// m_tready is low. Each byte goes through a single section state update between
// the input handshake and one output register, so a result appears on the m_
// channel in the cycle after the byte that causes it, and the next byte is taken
// while that result waits as long as m_tready is high in the same cycle. A
// record yields a header item, an optional repeat item, one item per kept text
// character, and an end-only item when its last byte causes nothing else.
module appointment_record_parser_core #(
    parameter int DESC_CAP   = apr_pkg::DESC_CAP_DEF,
    parameter int NOTE_CAP   = apr_pkg::NOTE_CAP_DEF,
    parameter int EXCEPT_CAP = apr_pkg::EXCEPT_CAP_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // s_tdata: data_byte[7:0]
    input  logic [apr_pkg::DATA_W-1:0]    s_tdata,
    input  logic                          s_tlast,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // m_tdata: flag_bit[0], year[11:1], month[15:12], day[20:16], value_a[28:21],
    // value_b[36:29], value_c[44:37], value_d[52:45], incomplete[53], zero[55:54]
    output logic [apr_pkg::M_TDATA_W-1:0] m_tdata,
    // m_tuser: kind[2:0]
    output logic [apr_pkg::KIND_W-1:0]    m_tuser,
    output logic                          m_tlast
);

    localparam int TXT_MAX = (DESC_CAP > NOTE_CAP) ? DESC_CAP : NOTE_CAP;
    localparam int TXT_W   = $clog2(TXT_MAX + 1);
    localparam int SKIP_W  = $clog2(2 * EXCEPT_CAP + 1);

    typedef enum logic [3:0] {
        ST_HEADER, ST_ALARM, ST_REPEAT, ST_EXC_COUNT, ST_EXC_SKIP,
        ST_DESC, ST_DESC_PAD, ST_NOTE, ST_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [2:0]        pos_reg, pos_next;
    logic [4:0]        flags_reg, flags_next;
    logic [SKIP_W-1:0] skip_reg, skip_next;
    logic [TXT_W-1:0]  txt_reg, txt_next;
    logic              par_reg, par_next;
    logic [7:0]        hdr_reg [0:5];
    logic [7:0]        rpt_reg [1:5];

    logic                          out_valid_reg, out_valid_next;
    logic [apr_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [apr_pkg::KIND_W-1:0]    out_kind_reg;
    logic                          out_last_reg;

    logic                          accept;
    logic                          emit;
    logic [apr_pkg::KIND_W-1:0]    kind;
    logic                          flag_bit;
    apr_pkg::date_t                date;
    logic [7:0]                    val_a, val_b, val_c, val_d;
    logic                          incomplete;
    logic [7:0]                    b;
    logic [15:0]                   rpt_word;
    logic [SKIP_W-2:0]             exc_n;

    function automatic state_t pick(input state_t from, input logic [4:0] fl);
        state_t s;
        if (from <= ST_ALARM && fl[apr_pkg::FLG_ALARM]) begin
            s = ST_ALARM;
        end else if (from <= ST_REPEAT && fl[apr_pkg::FLG_REPEAT]) begin
            s = ST_REPEAT;
        end else if (from <= ST_EXC_COUNT && fl[apr_pkg::FLG_EXC]) begin
            s = ST_EXC_COUNT;
        end else if (from <= ST_DESC && fl[apr_pkg::FLG_DESC]) begin
            s = ST_DESC;
        end else if (fl[apr_pkg::FLG_NOTE]) begin
            s = ST_NOTE;
        end else begin
            s = ST_DONE;
        end
        return s;
    endfunction

    assign accept   = s_tvalid && s_tready;
    assign s_tready = !out_valid_reg || m_tready;
    assign b        = s_tdata;
    assign rpt_word = {rpt_reg[2], rpt_reg[3]};
    assign exc_n    = (32'(b) > EXCEPT_CAP) ? (SKIP_W-1)'(EXCEPT_CAP) : b[SKIP_W-2:0];

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        flags_next = flags_reg;
        skip_next  = skip_reg;
        txt_next   = txt_reg;
        par_next   = par_reg;
        emit       = 1'b0;
        kind       = apr_pkg::KIND_HEADER;
        flag_bit   = 1'b0;
        date       = '0;
        val_a      = '0;
        val_b      = '0;
        val_c      = '0;
        val_d      = '0;
        incomplete = 1'b0;

        unique case (state_reg)
            ST_HEADER: begin
                if (pos_reg == 3'd7) begin
                    flags_next = b[5:1];
                    emit       = 1'b1;
                    kind       = apr_pkg::KIND_HEADER;
                    flag_bit   = !(hdr_reg[0] == apr_pkg::BYTE_ALL
                                   && hdr_reg[1] == apr_pkg::BYTE_ALL);
                    date       = apr_pkg::decode_date({hdr_reg[4], hdr_reg[5]});
                    val_a      = hdr_reg[0];
                    val_b      = hdr_reg[1];
                    val_c      = hdr_reg[2];
                    val_d      = hdr_reg[3];
                    state_next = pick(ST_ALARM, b[5:1]);
                    pos_next   = '0;
                    txt_next   = '0;
                    par_next   = 1'b0;
                end else begin
                    pos_next = pos_reg + 3'd1;
                end
            end
            ST_ALARM: begin
                if (pos_reg != 3'd0) begin
                    state_next = pick(ST_REPEAT, flags_reg);
                    pos_next   = '0;
                    txt_next   = '0;
                    par_next   = 1'b0;
                end else begin
                    pos_next = pos_reg + 3'd1;
                end
            end
            ST_REPEAT: begin
                if (pos_reg == 3'd7) begin
                    emit       = 1'b1;
                    kind       = apr_pkg::KIND_REPEAT;
                    flag_bit   = (rpt_word == apr_pkg::WORD_ALL);
                    date       = apr_pkg::decode_date(rpt_word);
                    val_a      = rpt_reg[1];
                    val_b      = rpt_reg[5];
                    val_c      = rpt_reg[4];
                    state_next = pick(ST_EXC_COUNT, flags_reg);
                    pos_next   = '0;
                    txt_next   = '0;
                    par_next   = 1'b0;
                end else begin
                    pos_next = pos_reg + 3'd1;
                end
            end
            ST_EXC_COUNT: begin
                if (pos_reg == 3'd0) begin
                    skip_next = (b != 8'd0) ? SKIP_W'(2 * EXCEPT_CAP) : '0;
                    pos_next  = 3'd1;
                end else begin
                    if (skip_reg == '0) begin
                        skip_next = {exc_n, 1'b0};
                    end
                    if (skip_reg == '0 && exc_n == '0) begin
                        state_next = pick(ST_DESC, flags_reg);
                        txt_next   = '0;
                        par_next   = 1'b0;
                    end else begin
                        state_next = ST_EXC_SKIP;
                    end
                    pos_next = '0;
                end
            end
            ST_EXC_SKIP: begin
                if (skip_reg > SKIP_W'(1)) begin
                    skip_next = skip_reg - SKIP_W'(1);
                end else begin
                    skip_next  = '0;
                    state_next = pick(ST_DESC, flags_reg);
                    pos_next   = '0;
                    txt_next   = '0;
                    par_next   = 1'b0;
                end
            end
            ST_DESC: begin
                par_next = !par_reg;
                if (b == 8'd0) begin
                    state_next = par_reg ? pick(ST_NOTE, flags_reg) : ST_DESC_PAD;
                    pos_next   = '0;
                    txt_next   = '0;
                    par_next   = 1'b0;
                end else if (txt_reg < TXT_W'(DESC_CAP)) begin
                    emit     = 1'b1;
                    kind     = apr_pkg::KIND_DESC;
                    val_a    = b;
                    txt_next = txt_reg + TXT_W'(1);
                end
            end
            ST_DESC_PAD: begin
                state_next = pick(ST_NOTE, flags_reg);
                pos_next   = '0;
                txt_next   = '0;
                par_next   = 1'b0;
            end
            ST_NOTE: begin
                if (b == 8'd0) begin
                    state_next = ST_DONE;
                    pos_next   = '0;
                    txt_next   = '0;
                    par_next   = 1'b0;
                end else if (txt_reg < TXT_W'(NOTE_CAP)) begin
                    emit     = 1'b1;
                    kind     = apr_pkg::KIND_NOTE;
                    val_a    = b;
                    txt_next = txt_reg + TXT_W'(1);
                end
            end
            default: begin
                state_next = ST_DONE;
            end
        endcase

        if (s_tlast) begin
            if (!emit) begin
                emit = 1'b1;
                kind = apr_pkg::KIND_END;
            end
            incomplete = (state_next == ST_HEADER || state_next == ST_ALARM
                          || state_next == ST_REPEAT || state_next == ST_EXC_COUNT
                          || state_next == ST_EXC_SKIP || state_next == ST_DESC);
            state_next = ST_HEADER;
            pos_next   = '0;
            txt_next   = '0;
            par_next   = 1'b0;
            flags_next = '0;
            skip_next  = '0;
        end
    end

    assign out_valid_next = accept ? emit : (out_valid_reg && !m_tready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_HEADER;
            pos_reg       <= '0;
            flags_reg     <= '0;
            skip_reg      <= '0;
            txt_reg       <= '0;
            par_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            if (accept) begin
                state_reg <= state_next;
                pos_reg   <= pos_next;
                flags_reg <= flags_next;
                skip_reg  <= skip_next;
                txt_reg   <= txt_next;
                par_reg   <= par_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && state_reg == ST_HEADER && pos_reg < 3'd6) begin
            hdr_reg[pos_reg] <= b;
        end
        if (accept && state_reg == ST_REPEAT && pos_reg != 3'd0 && pos_reg < 3'd6) begin
            rpt_reg[pos_reg] <= b;
        end
        if (accept && emit) begin
            out_data_reg <= {2'b00, incomplete, val_d, val_c, val_b, val_a,
                             date.day, date.month, date.year, flag_bit};
            out_kind_reg <= kind;
            out_last_reg <= s_tlast;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tlast  = out_last_reg;

    a_last_gives_end: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> m_tvalid && m_tlast)
        else $error("Last byte of a record did not produce a closing item.");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && s_tlast |=> state_reg == ST_HEADER && flags_reg == '0 && skip_reg == '0)
        else $error("Parser did not return to the header section after a record.");

    a_incomplete_at_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[53] |-> m_tlast)
        else $error("Incomplete flag raised on an item that does not close a record.");

    a_text_no_date: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == apr_pkg::KIND_DESC || m_tuser == apr_pkg::KIND_NOTE)
        |-> m_tdata[20:0] == '0 && m_tdata[52:29] == '0)
        else $error("Text item carries date or value fields.");

    a_desc_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DESC |-> txt_reg <= TXT_W'(DESC_CAP))
        else $error("Description character count passed its cap.");

endmodule

@@ sim/appointment_record_parser_core_tb.sv @@
// Self-checking testbench for appointment_record_parser_core: directed and random
// appointment records go in, and every result is checked against a predictor.
// Depends on apr_pkg and the parser RTL only.
module appointment_record_parser_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ITEM_TARGET    = 1850;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 10;
    localparam int REPORT_LINES   = 50;
    localparam logic [7:0] TEXT_END = 8'h00;

    class record_parse_scoreboard;
        typedef enum logic [3:0] {
            SEC_HEADER    = 4'd0,
            SEC_ALARM     = 4'd1,
            SEC_REPEAT    = 4'd2,
            SEC_EXC_COUNT = 4'd3,
            SEC_EXC_SKIP  = 4'd4,
            SEC_DESC      = 4'd5,
            SEC_DESC_PAD  = 4'd6,
            SEC_NOTE      = 4'd7,
            SEC_DONE      = 4'd8
        } section_e;

        typedef struct packed {
            logic [apr_pkg::KIND_W-1:0] kind;
            logic              flag;
            logic [10:0]       year;
            logic [3:0]        month;
            logic [4:0]        day;
            logic [7:0]        value_a;
            logic [7:0]        value_b;
            logic [7:0]        value_c;
            logic [7:0]        value_d;
            logic              record_end;
            logic              incomplete;
        } parse_result_t;

        section_e      section;
        int unsigned   position;
        logic [4:0]    flags;
        logic [7:0]    header_bytes[6];
        logic [7:0]    repeat_bytes[6];
        int unsigned   skip_left;
        int unsigned   text_len;
        bit            parity;
        parse_result_t expected_results[$];
        int unsigned   mismatch_count;
        int unsigned   result_index;

        function new();
            enter(SEC_HEADER);
            flags          = '0;
            skip_left      = 0;
            mismatch_count = 0;
            result_index   = 0;
        endfunction

        function void enter(section_e s);
            section  = s;
            position = 0;
            text_len = 0;
            parity   = 1'b0;
        endfunction

        function section_e next_section(section_e from);
            if (from <= SEC_ALARM && flags[apr_pkg::FLG_ALARM]) return SEC_ALARM;
            if (from <= SEC_REPEAT && flags[apr_pkg::FLG_REPEAT]) return SEC_REPEAT;
            if (from <= SEC_EXC_COUNT && flags[apr_pkg::FLG_EXC]) return SEC_EXC_COUNT;
            if (from <= SEC_DESC && flags[apr_pkg::FLG_DESC]) return SEC_DESC;
            if (from <= SEC_NOTE && flags[apr_pkg::FLG_NOTE]) return SEC_NOTE;
            return SEC_DONE;
        endfunction

        function void set_date(inout parse_result_t r, input logic [15:0] w);
            r.year  = 11'(w[15:9]) + apr_pkg::YEAR_BASE;
            r.month = w[8:5];
            r.day   = w[4:0];
        endfunction

        function int unsigned pending();
            return expected_results.size();
        endfunction

        function void note_byte(logic [7:0] b, logic last);
            parse_result_t r;
            bit            emit;
            int unsigned   n;
            logic [15:0]   w;
            r    = '0;
            emit = 1'b0;
            case (section)
                SEC_HEADER: begin
                    if (position < 6) header_bytes[position] = b;
                    if (position >= 7) begin
                        flags   = b[5:1];
                        emit    = 1'b1;
                        r.kind  = apr_pkg::KIND_HEADER;
                        r.flag  = !(header_bytes[0] == apr_pkg::BYTE_ALL
                                    && header_bytes[1] == apr_pkg::BYTE_ALL);
                        set_date(r, {header_bytes[4], header_bytes[5]});
                        r.value_a = header_bytes[0];
                        r.value_b = header_bytes[1];
                        r.value_c = header_bytes[2];
                        r.value_d = header_bytes[3];
                        enter(next_section(SEC_ALARM));
                    end else begin
                        position++;
                    end
                end
                SEC_ALARM: begin
                    position++;
                    if (position >= 2) enter(next_section(SEC_REPEAT));
                end
                SEC_REPEAT: begin
                    if (position < 6) repeat_bytes[position] = b;
                    if (position >= 7) begin
                        w       = {repeat_bytes[2], repeat_bytes[3]};
                        emit    = 1'b1;
                        r.kind  = apr_pkg::KIND_REPEAT;
                        r.flag  = (w == apr_pkg::WORD_ALL);
                        set_date(r, w);
                        r.value_a = repeat_bytes[1];
                        r.value_b = repeat_bytes[5];
                        r.value_c = repeat_bytes[4];
                        enter(next_section(SEC_EXC_COUNT));
                    end else begin
                        position++;
                    end
                end
                SEC_EXC_COUNT: begin
                    if (position == 0) begin
                        skip_left = (b != 0) ? 2 * apr_pkg::EXCEPT_CAP_DEF : 0;
                        position  = 1;
                    end else begin
                        if (skip_left == 0) begin
                            n         = (b > apr_pkg::EXCEPT_CAP_DEF)
                                      ? apr_pkg::EXCEPT_CAP_DEF : b;
                            skip_left = 2 * n;
                        end
                        if (skip_left == 0) begin
                            enter(next_section(SEC_DESC));
                        end else begin
                            section  = SEC_EXC_SKIP;
                            position = 0;
                        end
                    end
                end
                SEC_EXC_SKIP: begin
                    if (skip_left > 0) skip_left--;
                    if (skip_left == 0) enter(next_section(SEC_DESC));
                end
                SEC_DESC: begin
                    parity = !parity;
                    if (b == TEXT_END) begin
                        if (parity) enter(SEC_DESC_PAD);
                        else enter(next_section(SEC_NOTE));
                    end else if (text_len < apr_pkg::DESC_CAP_DEF) begin
                        emit      = 1'b1;
                        r.kind    = apr_pkg::KIND_DESC;
                        r.value_a = b;
                        text_len++;
                    end
                end
                SEC_DESC_PAD: begin
                    enter(next_section(SEC_NOTE));
                end
                SEC_NOTE: begin
                    if (b == TEXT_END) begin
                        enter(SEC_DONE);
                    end else if (text_len < apr_pkg::NOTE_CAP_DEF) begin
                        emit      = 1'b1;
                        r.kind    = apr_pkg::KIND_NOTE;
                        r.value_a = b;
                        text_len++;
                    end
                end
                default: begin
                    section = SEC_DONE;
                end
            endcase
            if (last) begin
                if (!emit) begin
                    emit   = 1'b1;
                    r.kind = apr_pkg::KIND_END;
                end
                r.record_end = 1'b1;
                r.incomplete = (section <= SEC_DESC);
                enter(SEC_HEADER);
                flags     = '0;
                skip_left = 0;
            end
            if (emit) expected_results.push_back(r);
        endfunction

        function void report(string msg);
            mismatch_count++;
            if (mismatch_count <= REPORT_LINES) $display("ERROR: %s", msg);
        endfunction

        function void compare_field(string name, int unsigned got, int unsigned want);
            if (got != want) begin
                report($sformatf("result %0d %s: got 0x%0h, expected 0x%0h",
                                 result_index, name, got, want));
            end
        endfunction

        function void check_result(logic [apr_pkg::M_TDATA_W-1:0] d,
                                   logic [apr_pkg::KIND_W-1:0] k, logic l);
            parse_result_t e;
            result_index++;
            if (expected_results.size() == 0) begin
                report($sformatf("result %0d of kind %0d arrived with nothing expected",
                                 result_index, k));
                return;
            end
            e = expected_results.pop_front();
            compare_field("kind", k, e.kind);
            compare_field("flag_bit", d[0], e.flag);
            compare_field("year", d[11:1], e.year);
            compare_field("month", d[15:12], e.month);
            compare_field("day", d[20:16], e.day);
            compare_field("value_a", d[28:21], e.value_a);
            compare_field("value_b", d[36:29], e.value_b);
            compare_field("value_c", d[44:37], e.value_c);
            compare_field("value_d", d[52:45], e.value_d);
            compare_field("incomplete", d[53], e.incomplete);
            compare_field("zero fill", d[55:54], 0);
            compare_field("record_end", l, e.record_end);
        endfunction
    endclass

    logic                          aclk     = 1'b0;
    logic                          aresetn  = 1'b0;
    logic                          s_tvalid = 1'b0;
    logic                          s_tready;
    logic [apr_pkg::DATA_W-1:0]    s_tdata  = '0;
    logic                          s_tlast  = 1'b0;
    logic                          m_tvalid;
    logic                          m_tready = 1'b0;
    logic [apr_pkg::M_TDATA_W-1:0] m_tdata;
    logic [apr_pkg::KIND_W-1:0]    m_tuser;
    logic                          m_tlast;

    record_parse_scoreboard sb = new();

    int          s_idle_pct = 20;
    int          m_idle_pct = 66;
    int          items_sent = 0;
    int          idle_cycles = 0;
    int          rec_idx = 0;
    bit          want_long_desc = 1'b0;
    bit          want_long_note = 1'b0;
    logic [7:0]  rec_q[$];

    appointment_record_parser_core u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(0, 99) >= m_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready) sb.note_byte(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser, m_tlast);
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    task automatic send_byte(input logic [7:0] b, input logic l);
        while ($urandom_range(0, 99) < s_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= l;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    task automatic send_record();
        for (int i = 0; i < rec_q.size(); i++) send_byte(rec_q[i], i == rec_q.size() - 1);
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.pending() != 0) @(posedge aclk);
    endtask

    task automatic push_random(input int n);
        repeat (n) rec_q.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic push_text(input int n);
        repeat (n) rec_q.push_back(8'($urandom_range(1, 255)));
    endtask

    // Most records are well formed with random content; some are cut short,
    // some carry trailing bytes and a few are plain noise.
    task automatic build_record();
        logic [7:0] flag_byte;
        logic [7:0] count_hi;
        logic [7:0] count_lo;
        int         shape;
        int         words;
        int         text_chars;
        int         cut;
        rec_q.delete();
        shape = (want_long_desc || want_long_note) ? 50 : $urandom_range(0, 99);
        if (shape < 8) begin
            push_random($urandom_range(1, 20));
            return;
        end
        if ($urandom_range(0, 4) == 0) begin
            rec_q.push_back(apr_pkg::BYTE_ALL);
            rec_q.push_back(apr_pkg::BYTE_ALL);
        end else begin
            push_random(2);
        end
        push_random(2);
        if ($urandom_range(0, 4) == 0) begin
            rec_q.push_back(apr_pkg::BYTE_ALL);
            rec_q.push_back(apr_pkg::BYTE_ALL);
        end else begin
            push_random(2);
        end
        push_random(1);
        flag_byte = 8'($urandom_range(0, 255));
        if (want_long_desc) flag_byte[apr_pkg::FLG_DESC+1] = 1'b1;
        if (want_long_note) flag_byte[apr_pkg::FLG_NOTE+1] = 1'b1;
        rec_q.push_back(flag_byte);
        if (flag_byte[apr_pkg::FLG_ALARM+1]) push_random(2);
        if (flag_byte[apr_pkg::FLG_REPEAT+1]) begin
            push_random(2);
            if ($urandom_range(0, 3) == 0) begin
                rec_q.push_back(apr_pkg::BYTE_ALL);
                rec_q.push_back(apr_pkg::BYTE_ALL);
            end else begin
                push_random(2);
            end
            push_random(4);
        end
        if (flag_byte[apr_pkg::FLG_EXC+1]) begin
            count_hi = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(1, 255)) : 8'd0;
            count_lo = ($urandom_range(0, 4) == 0)
                     ? 8'($urandom_range(0, 255))
                     : 8'($urandom_range(0, apr_pkg::EXCEPT_CAP_DEF + 2));
            rec_q.push_back(count_hi);
            rec_q.push_back(count_lo);
            words = (count_hi != 0) ? apr_pkg::EXCEPT_CAP_DEF
                  : ((count_lo > apr_pkg::EXCEPT_CAP_DEF) ? apr_pkg::EXCEPT_CAP_DEF
                                                          : count_lo);
            push_random(2 * words);
        end
        if (flag_byte[apr_pkg::FLG_DESC+1]) begin
            text_chars = want_long_desc
                       ? $urandom_range(apr_pkg::DESC_CAP_DEF - 2, apr_pkg::DESC_CAP_DEF + 8)
                       : $urandom_range(0, 12);
            push_text(text_chars);
            rec_q.push_back(TEXT_END);
            if (text_chars % 2 == 0) push_random(1);
        end
        if (flag_byte[apr_pkg::FLG_NOTE+1]) begin
            text_chars = want_long_note
                       ? $urandom_range(apr_pkg::NOTE_CAP_DEF - 2, apr_pkg::NOTE_CAP_DEF + 8)
                       : $urandom_range(0, 12);
            push_text(text_chars);
            if ($urandom_range(0, 4) != 0) rec_q.push_back(TEXT_END);
        end
        if (shape < 22) begin
            cut = $urandom_range(1, rec_q.size());
            while (rec_q.size() > cut) void'(rec_q.pop_back());
        end else if (shape < 32) begin
            push_random($urandom_range(1, 4));
        end
    endtask

    initial begin
        int phase_end;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        rec_q = '{8'h00, 8'hFF, 8'h7F};
        send_record();
        rec_q = '{8'hFF, 8'hFF, 8'h17, 8'h3B, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'h12, 8'h34,
                  8'h00, 8'h05, 8'hFF, 8'hFF, 8'h80, 8'h01, 8'hAA, 8'hBB,
                  8'h00, 8'h01, 8'hAB, 8'hCD,
                  8'h41, 8'h42, 8'h00, 8'h55,
                  8'h01, 8'hFF, 8'h00};
        send_record();

        for (int p = 0; p < 3; p++) begin
            case (p)
                0: begin
                    s_idle_pct = 20;
                    m_idle_pct = 66;
                end
                1: begin
                    s_idle_pct = 66;
                    m_idle_pct = 20;
                end
                default: begin
                    s_idle_pct = 0;
                    m_idle_pct = 0;
                end
            endcase
            if (p > 0) wait_drained();
            phase_end = items_sent + ITEM_TARGET / 3;
            while (items_sent < phase_end) begin
                want_long_desc = (rec_idx == 3) || ($urandom_range(0, 59) == 0);
                want_long_note = (rec_idx == 12) || ($urandom_range(0, 199) == 0);
                build_record();
                send_record();
                rec_idx++;
            end
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (sb.mismatch_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
